// ===== design/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants for the 3x3 RGB box filter: command and job
// records, the window type and the register and state codes.
// ----------------------------------------------------------------------------
package bf3_pkg;

    // fixed field widths
    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int ROW_W       = 12;
    localparam int OUT_COL_W   = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int WREG_W      = 11;
    localparam int HREG_W      = 13;
    localparam int MAX_HEIGHT  = 4096;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    // window: [row][col], row 0 oldest, col 0 leftmost
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_kind_t;

    // classified item handed from the front to the back
    typedef struct packed {
        cmd_kind_t              kind;
        pixel_t                 pix;
        logic [ROW_W-1:0]       row;
        logic                   emit_a;
        logic                   emit_b;
        logic                   rv_top;
        logic                   cv_left_a;
        logic                   cv_left_b;
        logic                   cv_right;
        logic                   last;
    } cmd_t;

    // one mean computation handed to the arithmetic pipeline
    typedef struct packed {
        win_t                   px;
        logic [2:0]             rmask;
        logic [2:0]             cmask;
        logic [OUT_COL_W-1:0]   col;
        logic [ROW_W-1:0]       row;
        logic                   last;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PIX_LOAD,
        BK_PIX_EMIT_A,
        BK_PIX_EMIT_B,
        BK_DR_LOAD0,
        BK_DR_LOAD1,
        BK_DR_LOAD2,
        BK_DR_EMIT
    } back_state_t;

endpackage

// ===== design/bf3_front.sv =====
// ----------------------------------------------------------------------------
// bf3_front
// Accepts stream transactions, tracks the raster position and the drain of
// the last row, and turns each transaction into a command for the back end.
// ----------------------------------------------------------------------------
module bf3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bf3_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic                                  s_tuser,
    input  logic                                  fifo_full,
    output logic                                  push,
    output bf3_pkg::cmd_t                         push_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]          push_col
);
    import bf3_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int MW_W    = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W  = (WREG_W > MW_W) ? WREG_W : MW_W;
    localparam int W_RESET = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam logic [COL_W-1:0] W_LAST_RESET = COL_W'(W_RESET - 1);
    localparam logic [ROW_W-1:0] H_LAST_RESET = ROW_W'(479);

    logic [COL_W-1:0]  w_last_reg, w_last_next;
    logic [ROW_W-1:0]  h_last_reg, h_last_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  drain_col_reg, drain_col_next;
    logic              drain_pending_reg, drain_pending_next;

    logic              accept;
    logic              is_drain;
    logic              wrap;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic              col_end;
    logic              row_end;
    logic              d_over;
    logic              d_end;
    logic [WCMP_W-1:0] w_ext;
    logic [HREG_W-1:0] h_raw;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign is_drain = (cmd_kind_t'(s_tuser) == CMD_DRAIN);

    // position of the incoming pixel, restarting after an out-of-frame count
    assign wrap    = (in_col_reg > w_last_reg) || (in_row_reg > h_last_reg);
    assign c       = wrap ? '0 : in_col_reg;
    assign r       = wrap ? '0 : in_row_reg;
    assign col_end = (c == w_last_reg);
    assign row_end = (r == h_last_reg);
    assign d_over  = (drain_col_reg > w_last_reg);
    assign d_end   = (drain_col_reg == w_last_reg);

    // command build
    always_comb begin
        push_cmd           = '0;
        push_cmd.kind      = is_drain ? CMD_DRAIN : CMD_PIXEL;
        push_cmd.pix       = pixel_t'(s_tdata);
        push_col           = is_drain ? drain_col_reg : c;
        push               = accept && (!is_drain || (drain_pending_reg && !d_over));
        if (is_drain) begin
            push_cmd.row       = h_last_reg;
            push_cmd.rv_top    = (h_last_reg != '0);
            push_cmd.cv_left_a = (drain_col_reg != '0);
            push_cmd.cv_right  = !d_end;
            push_cmd.last      = d_end;
        end else begin
            push_cmd.row       = r - ROW_W'(1);
            push_cmd.emit_a    = (r != '0) && (c != '0);
            push_cmd.emit_b    = (r != '0) && col_end;
            push_cmd.rv_top    = (r > ROW_W'(1));
            push_cmd.cv_left_a = (c > COL_W'(1));
            push_cmd.cv_left_b = (c != '0);
        end
    end

    // effective frame size from a register write
    assign w_ext = WCMP_W'(cfg_wdata[WREG_W-1:0]);
    assign h_raw = cfg_wdata[HREG_W-1:0];

    // next state of position, drain and frame size
    always_comb begin
        w_last_next        = w_last_reg;
        h_last_next        = h_last_reg;
        in_col_next        = in_col_reg;
        in_row_next        = in_row_reg;
        drain_col_next     = drain_col_reg;
        drain_pending_next = drain_pending_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (w_ext == '0) begin
                        w_last_next = '0;
                    end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
                        w_last_next = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        w_last_next = COL_W'(w_ext - WCMP_W'(1));
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (h_raw == '0) begin
                        h_last_next = '0;
                    end else if (h_raw > HREG_W'(MAX_HEIGHT)) begin
                        h_last_next = ROW_W'(MAX_HEIGHT - 1);
                    end else begin
                        h_last_next = ROW_W'(h_raw - HREG_W'(1));
                    end
                end
                default: begin
                end
            endcase
            in_col_next        = '0;
            in_row_next        = '0;
            drain_col_next     = '0;
            drain_pending_next = 1'b0;
        end else if (accept) begin
            if (is_drain) begin
                if (drain_pending_reg) begin
                    if (d_over || d_end) begin
                        drain_pending_next = 1'b0;
                        drain_col_next     = '0;
                    end else begin
                        drain_col_next = drain_col_reg + COL_W'(1);
                    end
                end
            end else begin
                drain_pending_next = 1'b0;
                if (col_end) begin
                    in_col_next = '0;
                    if (row_end) begin
                        in_row_next        = '0;
                        drain_pending_next = 1'b1;
                        drain_col_next     = '0;
                    end else begin
                        in_row_next = r + ROW_W'(1);
                    end
                end else begin
                    in_col_next = c + COL_W'(1);
                    in_row_next = r;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg        <= W_LAST_RESET;
            h_last_reg        <= H_LAST_RESET;
            in_col_reg        <= '0;
            in_row_reg        <= '0;
            drain_col_reg     <= '0;
            drain_pending_reg <= 1'b0;
        end else begin
            w_last_reg        <= w_last_next;
            h_last_reg        <= h_last_next;
            in_col_reg        <= in_col_next;
            in_row_reg        <= in_row_next;
            drain_col_reg     <= drain_col_next;
            drain_pending_reg <= drain_pending_next;
        end
    end

endmodule

// ===== design/bf3_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// bf3_cmd_fifo
// Short command queue between the front and the back end, head visible
// without a pop.
// ----------------------------------------------------------------------------
module bf3_cmd_fifo #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);
    import bf3_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/bf3_mean.sv =====
// ----------------------------------------------------------------------------
// bf3_mean
// Three-stage arithmetic pipeline: masked window sums, multiply by the
// reciprocal of twice the neighbour count, and the output register.
// ----------------------------------------------------------------------------
module bf3_mean (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    input  bf3_pkg::job_t                     job,
    output logic                              job_ready,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bf3_pkg::M_TDATA_W-1:0]     m_tdata,   // red, green, blue, out_col, out_row
    output logic                              m_tlast    // frame_last
);
    import bf3_pkg::*;

    localparam int SUM_W       = 12;
    localparam int N_W         = 13;
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 17;
    localparam int PROD_W      = N_W + RECIP_W;
    localparam int PAD_W       = M_TDATA_W - 3 * CH_W - OUT_COL_W - ROW_W;

    // number of neighbours inside the frame
    function automatic logic [3:0] win_count(input logic [2:0] rm, input logic [2:0] cm);
        logic [1:0] nr;
        logic [1:0] nc;
        nr = {1'b0, rm[0]} + {1'b0, rm[1]} + {1'b0, rm[2]};
        nc = {1'b0, cm[0]} + {1'b0, cm[1]} + {1'b0, cm[2]};
        return {2'b00, nr} * {2'b00, nc};
    endfunction

    // ceil(2^17 / (2*count)), exact floor for every reachable numerator
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

    logic                         ce;
    logic [3:0]                   cnt;
    logic [2:0][SUM_W-1:0]        sum;
    logic [2:0][N_W-1:0]          n_next;

    logic                         s1_valid_reg;
    logic [2:0][N_W-1:0]          s1_n_reg;
    logic [RECIP_W-1:0]           s1_recip_reg;
    logic [OUT_COL_W-1:0]         s1_col_reg;
    logic [ROW_W-1:0]             s1_row_reg;
    logic                         s1_last_reg;

    logic                         s2_valid_reg;
    logic [2:0][PROD_W-1:0]       s2_prod_reg;
    logic [2:0][PROD_W-1:0]       s2_prod_next;
    logic [OUT_COL_W-1:0]         s2_col_reg;
    logic [ROW_W-1:0]             s2_row_reg;
    logic                         s2_last_reg;

    logic                         out_valid_reg;
    logic [M_TDATA_W-1:0]         out_data_reg;
    logic [M_TDATA_W-1:0]         out_data_next;
    logic                         out_last_reg;

    // the whole pipe advances unless a result waits at the output
    assign ce        = !out_valid_reg || m_tready;
    assign job_ready = ce;

    // masked sums per channel
    always_comb begin
        cnt = win_count(job.rmask, job.cmask);
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (job.rmask[i] && job.cmask[j]) begin
                        sum[ch] = sum[ch] + SUM_W'(job.px[i][j][ch*CH_W +: CH_W]);
                    end
                end
            end
            n_next[ch] = {sum[ch], 1'b0} + N_W'(cnt);
        end
    end

    // reciprocal products
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s2_prod_next[ch] = PROD_W'(s1_n_reg[ch]) * PROD_W'(s1_recip_reg);
        end
    end

    // quotient extraction and result packing
    assign out_data_next = {{PAD_W{1'b0}}, s2_row_reg, s2_col_reg,
                            s2_prod_reg[2][RECIP_SHIFT +: CH_W],
                            s2_prod_reg[1][RECIP_SHIFT +: CH_W],
                            s2_prod_reg[0][RECIP_SHIFT +: CH_W]};

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_n_reg     <= n_next;
            s1_recip_reg <= recip(cnt);
            s1_col_reg   <= job.col;
            s1_row_reg   <= job.row;
            s1_last_reg  <= job.last;
            s2_prod_reg  <= s2_prod_next;
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_last_reg  <= s1_last_reg;
            out_data_reg <= out_data_next;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/bf3_back.sv =====
// ----------------------------------------------------------------------------
// bf3_back
// Carries out commands: owns the two-row line memory and the 3x3 window,
// and issues mean jobs to the arithmetic pipeline.
// ----------------------------------------------------------------------------
module bf3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fifo_empty,
    input  bf3_pkg::cmd_t                     head_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]      head_col,
    output logic                              cmd_pop,
    output logic                              job_valid,
    output bf3_pkg::job_t                     job,
    input  logic                              job_ready
);
    import bf3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int LINE_W = 2 * PIX_W;

    typedef enum logic [1:0] {
        JOB_A,
        JOB_B,
        JOB_DRAIN
    } job_sel_t;

    back_state_t        state_reg, state_next;
    cmd_t               cur_cmd_reg;
    logic [COL_W-1:0]   cur_col_reg;
    win_t               win_reg;

    // line memory: older row in the upper half, newer row in the lower half
    logic [LINE_W-1:0]  line_mem [MAX_WIDTH];
    logic [LINE_W-1:0]  rd_data_reg;

    logic               mem_re;
    logic               mem_we;
    logic [COL_W-1:0]   mem_rd_addr;
    logic               win_shift;
    job_sel_t           job_sel;
    pixel_t             new_bottom;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!fifo_empty) begin
                    state_next = (head_cmd.kind == CMD_DRAIN) ? BK_DR_LOAD0 : BK_PIX_LOAD;
                end
            end
            BK_PIX_LOAD: begin
                if (cur_cmd_reg.emit_a) begin
                    state_next = BK_PIX_EMIT_A;
                end else if (cur_cmd_reg.emit_b) begin
                    state_next = BK_PIX_EMIT_B;
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_PIX_EMIT_A: begin
                if (job_ready) begin
                    state_next = cur_cmd_reg.emit_b ? BK_PIX_EMIT_B : BK_IDLE;
                end
            end
            BK_PIX_EMIT_B: begin
                if (job_ready) begin
                    state_next = BK_IDLE;
                end
            end
            BK_DR_LOAD0: state_next = BK_DR_LOAD1;
            BK_DR_LOAD1: state_next = BK_DR_LOAD2;
            BK_DR_LOAD2: state_next = BK_DR_EMIT;
            BK_DR_EMIT: begin
                if (job_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs per state
    always_comb begin
        cmd_pop     = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_rd_addr = cur_col_reg;
        win_shift   = 1'b0;
        job_valid   = 1'b0;
        job_sel     = JOB_A;
        case (state_reg)
            BK_IDLE: begin
                cmd_pop     = !fifo_empty;
                mem_re      = !fifo_empty;
                mem_rd_addr = (head_cmd.kind == CMD_DRAIN) ? head_col - COL_W'(1) : head_col;
            end
            BK_PIX_LOAD: begin
                mem_we    = 1'b1;
                win_shift = 1'b1;
            end
            BK_PIX_EMIT_A: begin
                job_valid = job_ready;
                job_sel   = JOB_A;
            end
            BK_PIX_EMIT_B: begin
                job_valid = job_ready;
                job_sel   = JOB_B;
            end
            BK_DR_LOAD0: begin
                win_shift   = 1'b1;
                mem_re      = 1'b1;
                mem_rd_addr = cur_col_reg;
            end
            BK_DR_LOAD1: begin
                win_shift   = 1'b1;
                mem_re      = 1'b1;
                mem_rd_addr = cur_col_reg + COL_W'(1);
            end
            BK_DR_LOAD2: begin
                win_shift = 1'b1;
            end
            BK_DR_EMIT: begin
                job_valid = job_ready;
                job_sel   = JOB_DRAIN;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command latch
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cur_cmd_reg <= head_cmd;
            cur_col_reg <= head_col;
        end
    end

    // line memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[cur_col_reg] <= {rd_data_reg[PIX_W-1:0], cur_cmd_reg.pix};
        end
        if (mem_re) begin
            rd_data_reg <= line_mem[mem_rd_addr];
        end
    end

    // window shift, new column enters on the right
    assign new_bottom = (state_reg == BK_PIX_LOAD) ? cur_cmd_reg.pix : '0;

    always_ff @(posedge aclk) begin
        if (win_shift) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_data_reg[LINE_W-1:PIX_W];
            win_reg[1][2] <= rd_data_reg[PIX_W-1:0];
            win_reg[2][2] <= new_bottom;
        end
    end

    // job build
    always_comb begin
        job       = '0;
        job.px    = win_reg;
        job.row   = cur_cmd_reg.row;
        job.rmask = {1'b1, 1'b1, cur_cmd_reg.rv_top};
        job.cmask = {1'b1, 1'b1, cur_cmd_reg.cv_left_a};
        job.col   = OUT_COL_W'(cur_col_reg - COL_W'(1));
        case (job_sel)
            JOB_A: begin
            end
            JOB_B: begin
                for (int i = 0; i < 3; i++) begin
                    job.px[i][0] = win_reg[i][1];
                    job.px[i][1] = win_reg[i][2];
                    job.px[i][2] = '0;
                end
                job.cmask = {1'b0, 1'b1, cur_cmd_reg.cv_left_b};
                job.col   = OUT_COL_W'(cur_col_reg);
            end
            JOB_DRAIN: begin
                job.rmask = {1'b0, 1'b1, cur_cmd_reg.rv_top};
                job.cmask = {cur_cmd_reg.cv_right, 1'b1, cur_cmd_reg.cv_left_a};
                job.col   = OUT_COL_W'(cur_col_reg);
                job.last  = cur_cmd_reg.last;
            end
            default: begin
            end
        endcase
    end

    // checks
    a_issue_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> job_ready)
        else $error("mean job issued while the pipeline is stalled");

    a_load_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_PIX_LOAD) |-> $past(mem_re))
        else $error("pixel load without a preceding line memory read");

    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |=> (state_reg != BK_IDLE))
        else $error("command popped but back end stayed idle");

endmodule

// ===== design/box_filter_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb
// Streaming 3x3 mean filter for RGB pixels in raster order. Each result is
// the per-channel mean of the pixel's neighbourhood, neighbours outside the
// frame left out, rounded half up. A row's results leave while the next row
// streams in; the final row comes out one result per drain transaction
// (s_tuser high). The front end takes one transaction per clock into a
// four-deep command queue, unless the queue is full. The back end works one
// command at a time around a single-port line memory: a pixel reads its
// column, loads it and then issues each result it releases, and a drain
// reads its three columns before it issues its one result. Results pass
// through a three-stage arithmetic pipeline, which stalls while a result
// waits with m_tready low. A register write restarts the frame and must be
// made only while the block is idle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb #(
    parameter int MAX_WIDTH = 1024,
    parameter int CMD_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bf3_pkg::S_TDATA_W-1:0]     s_tdata,   // red_in, green_in, blue_in
    input  logic                              s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bf3_pkg::M_TDATA_W-1:0]     m_tdata,   // red, green, blue, out_col, out_row
    output logic                              m_tlast    // frame_last
);
    import bf3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int FIFO_W = $bits(cmd_t) + COL_W;

    logic               push;
    cmd_t               push_cmd;
    logic [COL_W-1:0]   push_col;
    logic               fifo_full;
    logic               fifo_empty;
    logic               cmd_pop;
    logic [FIFO_W-1:0]  fifo_rdata;
    cmd_t               head_cmd;
    logic [COL_W-1:0]   head_col;
    logic               job_valid;
    logic               job_ready;
    job_t               job;

    // item classification and raster tracking
    bf3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_col  (push_col)
    );

    // command queue
    bf3_cmd_fifo #(
        .DATA_W (FIFO_W),
        .DEPTH  (CMD_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   ({push_cmd, push_col}),
        .full    (fifo_full),
        .pop     (cmd_pop),
        .rdata   (fifo_rdata),
        .empty   (fifo_empty)
    );

    assign head_cmd = cmd_t'(fifo_rdata[FIFO_W-1:COL_W]);
    assign head_col = fifo_rdata[COL_W-1:0];

    // line memory, window and job sequencing
    bf3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .head_cmd   (head_cmd),
        .head_col   (head_col),
        .cmd_pop    (cmd_pop),
        .job_valid  (job_valid),
        .job        (job),
        .job_ready  (job_ready)
    );

    // mean arithmetic and output register
    bf3_mean u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
